### src/sfb_pkg.sv
// Shared types, codes and the CRC-16 byte update for the serial frame builder.
`timescale 1ns / 1ps

package sfb_pkg;

    // Operation codes of an input item
    localparam logic [1:0] OP_START_READ  = 2'd0;
    localparam logic [1:0] OP_START_WRITE = 2'd1;
    localparam logic [1:0] OP_BYTE        = 2'd2;

    // CRC-16 polynomial, MSB-first
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Control byte bits of the header
    localparam int CTRL_READ_BIT  = 7;
    localparam int CTRL_COUNT_BIT = 6;

    // Frame phase
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RDATA,
        PH_WDATA,
        PH_CRC_LOW,
        PH_CRC_HIGH
    } t_phase;

    // Result kind
    typedef enum logic [2:0] {
        K_HEADER,
        K_RDATA,
        K_WDATA,
        K_CRC_LOW,
        K_DONE,
        K_IGNORED
    } t_kind;

    typedef struct packed {
        logic [7:0]  tx_byte;
        logic [7:0]  rx_data;
        t_kind       kind;
        logic        crc_ok;
        logic [15:0] computed_crc;
        logic        last;
    } t_result;

    // Up to three results caused by one item, entry 0 goes out first
    typedef struct packed {
        logic [1:0]        count;
        t_result [2:0]     res;
    } t_group;

    // One byte folded into the CRC, eight shift steps
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### src/sfb_in_if.sv
// Input channel: valid/ready handshake carrying one frame item.
`timescale 1ns / 1ps

interface sfb_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [10:0] address;
    logic [8:0]  count;
    logic [7:0]  data_byte;

    modport source (output valid, output operation, output address, output count,
                    output data_byte, input ready);
    modport sink   (input valid, input operation, input address, input count,
                    input data_byte, output ready);
endinterface

### src/sfb_out_if.sv
// Output channel: valid/ready handshake carrying one result.
`timescale 1ns / 1ps

interface sfb_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  tx_byte;
    logic [7:0]  rx_data;
    logic [2:0]  kind;
    logic        crc_ok;
    logic [15:0] computed_crc;
    logic        last;

    modport source (output valid, output tx_byte, output rx_data, output kind,
                    output crc_ok, output computed_crc, output last, input ready);
    modport sink   (input valid, input tx_byte, input rx_data, input kind,
                    input crc_ok, input computed_crc, input last, output ready);
endinterface

### src/sfb_result_buf.sv
// Result buffer: holds the results of one item and sends them one per transfer.
`timescale 1ns / 1ps

module sfb_result_buf import sfb_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  t_group          i_group,
    output logic            o_ready,
    sfb_out_if.source       o_out
);

    logic [1:0]     r_cnt;
    t_result [2:0]  r_res;
    logic           out_fire;

    assign out_fire = o_out.valid && o_out.ready;

    // A new group may enter once the current one is empty or its last result leaves
    assign o_ready = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && o_out.ready);

    // Remaining count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_group.count;
        end else if (out_fire) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // Result entries, shifted down as each one goes out
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_group.res;
        end else if (out_fire) begin
            r_res[0] <= r_res[1];
            r_res[1] <= r_res[2];
        end
    end

    assign o_out.valid        = (r_cnt != 2'd0);
    assign o_out.tx_byte      = r_res[0].tx_byte;
    assign o_out.rx_data      = r_res[0].rx_data;
    assign o_out.kind         = r_res[0].kind;
    assign o_out.crc_ok       = r_res[0].crc_ok;
    assign o_out.computed_crc = r_res[0].computed_crc;
    assign o_out.last         = r_res[0].last;

endmodule

### src/spi_frame_builder_crc_checker_unit.sv
// Top level: frame builder with CRC-16 check on read frames.
// Flow: an item transferred in is held in the input register until the result buffer
//   takes its group; its first result is offered once the group is loaded there.
// Throughput: one byte item per cycle while the output accepts every result; a start item
//   gives three header results sharing the single output channel, so the next item waits.
// Reset (synchronous, active low) clears phase, byte count, CRC, held CRC low byte and valid flags.
`timescale 1ns / 1ps

module spi_frame_builder_crc_checker_unit import sfb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sfb_in_if.sink      i_in,
    sfb_out_if.source   o_out
);

    // Input register
    logic        r_in_valid;
    logic [1:0]  r_op;
    logic [10:0] r_addr;
    logic [8:0]  r_count;
    logic [7:0]  r_data;

    // Frame state
    t_phase      r_phase, n_phase;
    logic [8:0]  r_bytes_left, n_bytes_left;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_crc_low, n_crc_low;

    logic        grp_ready;
    logic        proc_fire;
    t_group      grp;

    logic        rd;
    logic [7:0]  h0, h1, h2;
    logic [15:0] c1, c2, c3;
    logic [15:0] crc_data;
    logic [8:0]  bytes_dec;

    assign proc_fire  = r_in_valid && grp_ready;
    assign i_in.ready = !r_in_valid || grp_ready;

    // Input register: take a transfer whenever it is empty or the held item moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (proc_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_op    <= i_in.operation;
            r_addr  <= i_in.address;
            r_count <= i_in.count;
            r_data  <= i_in.data_byte;
        end
    end

    // Header bytes and their CRC chain (read frames only)
    assign rd = (r_op == OP_START_READ);
    assign h0 = r_addr[7:0];
    always_comb begin
        h1 = 8'h00;
        h1[CTRL_READ_BIT]  = rd;
        h1[CTRL_COUNT_BIT] = r_count[8];
        h1[2:0]            = r_addr[10:8];
    end
    assign h2 = r_count[7:0];

    assign c1 = rd ? crc16_byte(16'h0000, h0) : 16'h0000;
    assign c2 = rd ? crc16_byte(c1, h1) : 16'h0000;
    assign c3 = rd ? crc16_byte(c2, h2) : 16'h0000;

    assign crc_data  = crc16_byte(r_crc, r_data);
    assign bytes_dec = r_bytes_left - 9'd1;

    // Next state and result group for the held item
    always_comb begin
        n_phase      = r_phase;
        n_bytes_left = r_bytes_left;
        n_crc        = r_crc;
        n_crc_low    = r_crc_low;
        grp          = '0;
        grp.count    = 2'd1;
        grp.res[0].kind         = K_IGNORED;
        grp.res[0].computed_crc = r_crc;
        grp.res[0].last         = 1'b1;

        unique case (r_op) inside
            OP_START_READ, OP_START_WRITE: begin
                grp.count = 2'd3;
                grp.res[0] = '{tx_byte: h0, rx_data: 8'h00, kind: K_HEADER, crc_ok: 1'b0,
                               computed_crc: c1, last: 1'b0};
                grp.res[1] = '{tx_byte: h1, rx_data: 8'h00, kind: K_HEADER, crc_ok: 1'b0,
                               computed_crc: c2, last: 1'b0};
                grp.res[2] = '{tx_byte: h2, rx_data: 8'h00, kind: K_HEADER, crc_ok: 1'b0,
                               computed_crc: c3, last: 1'b1};
                n_crc        = c3;
                n_crc_low    = 8'h00;
                n_bytes_left = r_count;
                if (rd) begin
                    n_phase = (r_count != 9'd0) ? PH_RDATA : PH_CRC_LOW;
                end else begin
                    n_phase = (r_count != 9'd0) ? PH_WDATA : PH_IDLE;
                end
            end
            OP_BYTE: begin
                unique case (r_phase)
                    PH_RDATA: begin
                        n_crc                   = crc_data;
                        n_bytes_left            = bytes_dec;
                        grp.res[0].kind         = K_RDATA;
                        grp.res[0].rx_data      = r_data;
                        grp.res[0].computed_crc = crc_data;
                        if (bytes_dec == 9'd0) begin
                            n_phase = PH_CRC_LOW;
                        end
                    end
                    PH_WDATA: begin
                        n_bytes_left       = bytes_dec;
                        grp.res[0].kind    = K_WDATA;
                        grp.res[0].tx_byte = r_data;
                        if (bytes_dec == 9'd0) begin
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_CRC_LOW: begin
                        n_crc_low       = r_data;
                        grp.res[0].kind = K_CRC_LOW;
                        n_phase         = PH_CRC_HIGH;
                    end
                    PH_CRC_HIGH: begin
                        grp.res[0].kind   = K_DONE;
                        grp.res[0].crc_ok = ({r_data, r_crc_low} == r_crc);
                        n_phase           = PH_IDLE;
                    end
                    default: begin
                        // byte while idle: ignored result, already set up
                    end
                endcase
            end
            default: begin
                // reserved operation: ignored result, state kept
            end
        endcase
    end

    // Frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bytes_left <= 9'd0;
            r_crc        <= 16'h0000;
            r_crc_low    <= 8'h00;
        end else if (proc_fire) begin
            r_phase      <= n_phase;
            r_bytes_left <= n_bytes_left;
            r_crc        <= n_crc;
            r_crc_low    <= n_crc_low;
        end
    end

    sfb_result_buf u_result_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (proc_fire),
        .i_group (grp),
        .o_ready (grp_ready),
        .o_out   (o_out)
    );

endmodule

### src/sfb_checker.sv
// Port-level checks for the frame builder, bound to the top level.
`timescale 1ns / 1ps

module sfb_checker import sfb_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        o_ready,
    input logic [7:0]  o_tx_byte,
    input logic [7:0]  o_rx_data,
    input logic [2:0]  o_kind,
    input logic        o_crc_ok,
    input logic [15:0] o_computed_crc,
    input logic        o_last
);

    // A stalled result holds its payload
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ready |=> o_valid && $stable({o_tx_byte, o_rx_data, o_kind,
                                                    o_crc_ok, o_computed_crc, o_last}))
        else $error("result changed while stalled");

    // Nothing is offered right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result offered after reset");

    // A header that is not the last one is followed by another header
    a_header_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_ready && (o_kind == K_HEADER) && !o_last
            |=> o_valid && (o_kind == K_HEADER))
        else $error("header run broken");

    // A CRC match is flagged only on the closing result of a read frame
    a_ok_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_crc_ok |-> (o_kind == K_DONE) && o_last)
        else $error("crc_ok outside done result");

    // Write data carries no CRC and no received byte
    a_write_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == K_WDATA) |-> (o_computed_crc == 16'h0000) && (o_rx_data == 8'h00))
        else $error("write data result has crc or rx data");

endmodule

bind spi_frame_builder_crc_checker_unit sfb_checker u_sfb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_out.valid),
    .o_ready        (o_out.ready),
    .o_tx_byte      (o_out.tx_byte),
    .o_rx_data      (o_out.rx_data),
    .o_kind         (o_out.kind),
    .o_crc_ok       (o_out.crc_ok),
    .o_computed_crc (o_out.computed_crc),
    .o_last         (o_out.last)
);
